### rtl/core/gcpb_pkg.sv
// Shared types, constants and helper functions for the glyph coverage pixel blender.
`default_nettype none

package gcpb_pkg;

    // Glyph depth codes.
    localparam logic [1:0] DEPTH_1BIT = 2'd0;
    localparam logic [1:0] DEPTH_4BIT = 2'd1;
    localparam logic [1:0] DEPTH_8BIT = 2'd2;

    // Framebuffer format codes.
    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGB888   = 2'd1;
    localparam logic [1:0] FMT_RGBA8888 = 2'd2;
    localparam logic [1:0] FMT_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_GLYPH_DEPTH  = 2'd0;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
    localparam logic [1:0] REG_TEXT_COLOR   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0]  RST_GLYPH_DEPTH  = 2'd0;
    localparam logic [1:0]  RST_PIXEL_FORMAT = 2'd0;
    localparam logic [31:0] RST_TEXT_COLOR   = 32'hFFFF_FFFF;

    // RGB565 channels spread apart so all three interpolate in one word.
    localparam logic [31:0] MASK565 = 32'h07E0_F81F;

    // Channel maxima used to reduce the 8-bit text color to RGB565.
    localparam logic [7:0] MAX5 = 8'h1F;
    localparam logic [7:0] MAX6 = 8'h3F;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [1:0]  glyph_depth;
        logic [1:0]  pixel_format;
        logic [31:0] text_color;
        logic [31:0] fg_spread;   // text color in RGB565, spread with MASK565
    } t_cfg;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_en;

    // Exact x / 255 for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
            return t[15:8];
        end
    endfunction

    // Spread a 16-bit RGB565 pixel across a word as (p | p << 16) & MASK565.
    function automatic logic [31:0] spread565(input logic [15:0] p);
        begin
            return {p, p} & MASK565;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/glyph_coverage_pixel_blender.sv
// Top level of the glyph coverage pixel blender: configuration, pipeline control, datapath.
`default_nettype none

// Blends text color over one framebuffer pixel per item, weighted by the glyph
// coverage (1, 4 or 8 bits per pixel) and the text alpha, in RGB565, RGB888 or
// RGBA8888. The pipeline has four register stages: coverage and alpha multiply,
// divide by 255, channel multiplies, then the final divides and format select,
// whose register drives the output. An item is accepted every cycle while o_in_stall
// is low, and its result moves through the stage registers in that order to the
// outputs; a stall on the output holds the pipeline while empty stages keep filling.
// Configuration is written through a port that is always ready, and items accepted
// from the cycle after the write see the new values.
module glyph_coverage_pixel_blender (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input item channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_dot_byte,
    input  wire logic [2:0]  i_column_in_byte,
    input  wire logic [31:0] i_background,
    // Result item channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_pixel_out,
    output logic             o_write_enable
);

    logic [1:0]  r_glyph_depth;
    logic [1:0]  r_pixel_format;
    logic [31:0] r_text_color;
    logic [31:0] r_fg_spread;
    logic [7:0]  fg_r5;
    logic [7:0]  fg_g6;
    logic [7:0]  fg_b5;
    logic [15:0] n_fg565;
    logic        cfg_wr;

    logic [3:0]  r_vld;
    logic [3:0]  stage_ready;

    gcpb_pkg::t_cfg     cfg;
    gcpb_pkg::t_pipe_en pipe_en;

    logic [7:0]  weight;
    logic        cov;
    logic [31:0] bg1;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_depth  <= gcpb_pkg::RST_GLYPH_DEPTH;
            r_pixel_format <= gcpb_pkg::RST_PIXEL_FORMAT;
            r_text_color   <= gcpb_pkg::RST_TEXT_COLOR;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                gcpb_pkg::REG_GLYPH_DEPTH:  r_glyph_depth  <= i_cfg_data[1:0];
                gcpb_pkg::REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[1:0];
                gcpb_pkg::REG_TEXT_COLOR:   r_text_color   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Text color reduced to RGB565 and spread for the packed blend.
    always_comb begin
        fg_r5   = gcpb_pkg::div255(16'(r_text_color[31:24]) * 16'(gcpb_pkg::MAX5));
        fg_g6   = gcpb_pkg::div255(16'(r_text_color[23:16]) * 16'(gcpb_pkg::MAX6));
        fg_b5   = gcpb_pkg::div255(16'(r_text_color[15:8]) * 16'(gcpb_pkg::MAX5));
        n_fg565 = {fg_r5[4:0], fg_g6[5:0], fg_b5[4:0]};
    end

    always_ff @(posedge i_clk) begin
        r_fg_spread <= gcpb_pkg::spread565(n_fg565);
    end

    assign cfg.glyph_depth  = r_glyph_depth;
    assign cfg.pixel_format = r_pixel_format;
    assign cfg.text_color   = r_text_color;
    assign cfg.fg_spread    = r_fg_spread;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        stage_ready[3] = !r_vld[3] || !i_out_stall;
        stage_ready[2] = !r_vld[2] || stage_ready[3];
        stage_ready[1] = !r_vld[1] || stage_ready[2];
        stage_ready[0] = !r_vld[0] || stage_ready[1];
    end

    assign pipe_en.ld0 = stage_ready[0];
    assign pipe_en.ld1 = stage_ready[1];
    assign pipe_en.ld2 = stage_ready[2];
    assign pipe_en.ld3 = stage_ready[3];

    assign o_in_stall  = !stage_ready[0];
    assign o_out_valid = r_vld[3];

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else begin
            if (stage_ready[0]) begin
                r_vld[0] <= i_in_valid;
            end
            if (stage_ready[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (stage_ready[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (stage_ready[3]) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    gcpb_cover u_cover (
        .i_clk            (i_clk),
        .i_cfg            (cfg),
        .i_en             (pipe_en),
        .i_dot_byte       (i_dot_byte),
        .i_column_in_byte (i_column_in_byte),
        .i_background     (i_background),
        .o_weight         (weight),
        .o_cov            (cov),
        .o_background     (bg1)
    );

    gcpb_mix u_mix (
        .i_clk          (i_clk),
        .i_cfg          (cfg),
        .i_en           (pipe_en),
        .i_weight       (weight),
        .i_cov          (cov),
        .i_background   (bg1),
        .o_pixel_out    (o_pixel_out),
        .o_write_enable (o_write_enable)
    );

endmodule

`default_nettype wire

### rtl/core/gcpb_cover.sv
// Coverage extraction and blend weight: pipeline stages zero and one.
`default_nettype none

module gcpb_cover (
    input  wire logic              i_clk,
    input  wire gcpb_pkg::t_cfg    i_cfg,
    input  wire gcpb_pkg::t_pipe_en i_en,
    input  wire logic [7:0]        i_dot_byte,
    input  wire logic [2:0]        i_column_in_byte,
    input  wire logic [31:0]       i_background,
    output logic [7:0]             o_weight,
    output logic                   o_cov,
    output logic [31:0]            o_background
);

    logic [3:0]  nib;
    logic        cov;
    logic [7:0]  mul_op;
    logic [15:0] prod;
    logic [7:0]  ta;
    logic [7:0]  n_weight;

    logic [15:0] r_prod;
    logic        r_cov0;
    logic [31:0] r_bg0;
    logic [7:0]  r_weight;
    logic        r_cov1;
    logic [31:0] r_bg1;

    assign ta = i_cfg.text_color[7:0];

    // Stage zero: pick the coverage and scale the text alpha by it.
    always_comb begin
        nib    = i_column_in_byte[0] ? i_dot_byte[3:0] : i_dot_byte[7:4];
        cov    = 1'b0;
        mul_op = i_dot_byte;
        unique case (i_cfg.glyph_depth)
            gcpb_pkg::DEPTH_1BIT: begin
                cov = i_dot_byte[3'd7 - i_column_in_byte];
            end
            gcpb_pkg::DEPTH_4BIT: begin
                cov    = (nib != 4'd0);
                mul_op = {nib, 4'd0};
            end
            gcpb_pkg::DEPTH_8BIT: begin
                cov = (i_dot_byte != 8'd0);
            end
            default: begin
                cov = 1'b0;
            end
        endcase
        if (i_cfg.pixel_format == gcpb_pkg::FMT_UNUSED) begin
            cov = 1'b0;
        end
        prod = 16'(ta) * 16'(mul_op);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld0) begin
            r_prod <= prod;
            r_cov0 <= cov;
            r_bg0  <= i_background;
        end
    end

    // Stage one: one-bit coverage takes the alpha as is, otherwise divide by 255.
    always_comb begin
        if (i_cfg.glyph_depth == gcpb_pkg::DEPTH_1BIT) begin
            n_weight = ta;
        end else begin
            n_weight = gcpb_pkg::div255(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_weight <= n_weight;
            r_cov1   <= r_cov0;
            r_bg1    <= r_bg0;
        end
    end

    assign o_weight     = r_weight;
    assign o_cov        = r_cov1;
    assign o_background = r_bg1;

endmodule

`default_nettype wire

### rtl/core/gcpb_mix.sv
// Color blending in three framebuffer formats: pipeline stages two and three.
`default_nettype none

module gcpb_mix (
    input  wire logic               i_clk,
    input  wire gcpb_pkg::t_cfg     i_cfg,
    input  wire gcpb_pkg::t_pipe_en i_en,
    input  wire logic [7:0]         i_weight,
    input  wire logic               i_cov,
    input  wire logic [31:0]        i_background,
    output logic [31:0]             o_pixel_out,
    output logic                    o_write_enable
);

    logic [7:0]  cr;
    logic [7:0]  cg;
    logic [7:0]  cb;
    logic [7:0]  bg_r;
    logic [7:0]  bg_g;
    logic [7:0]  bg_b;
    logic [7:0]  inv_w;
    logic [8:0]  a5_sum;
    logic [5:0]  a5;
    logic [31:0] bgx;
    logic [31:0] diff;
    logic [15:0] n_sum_r;
    logic [15:0] n_sum_g;
    logic [15:0] n_sum_b;
    logic [31:0] n_p565;

    logic [15:0] r_sum_r;
    logic [15:0] r_sum_g;
    logic [15:0] r_sum_b;
    logic [31:0] r_p565;
    logic        r_cov2;
    logic [31:0] r_bg2;

    logic [31:0] bgx3;
    logic [31:0] res565;
    logic [15:0] fold565;
    logic [7:0]  mr;
    logic [7:0]  mg;
    logic [7:0]  mb;
    logic [31:0] n_pixel;

    logic [31:0] r_pixel;
    logic        r_we;

    assign cr = i_cfg.text_color[31:24];
    assign cg = i_cfg.text_color[23:16];
    assign cb = i_cfg.text_color[15:8];

    // Stage two: per-channel products and the packed RGB565 product.
    always_comb begin
        if (i_cfg.pixel_format == gcpb_pkg::FMT_RGB888) begin
            bg_r = i_background[23:16];
            bg_g = i_background[15:8];
            bg_b = i_background[7:0];
        end else begin
            bg_r = i_background[31:24];
            bg_g = i_background[23:16];
            bg_b = i_background[15:8];
        end
        inv_w   = 8'hFF - i_weight;
        n_sum_r = 16'(cr) * 16'(i_weight) + 16'(bg_r) * 16'(inv_w);
        n_sum_g = 16'(cg) * 16'(i_weight) + 16'(bg_g) * 16'(inv_w);
        n_sum_b = 16'(cb) * 16'(i_weight) + 16'(bg_b) * 16'(inv_w);

        a5_sum = {1'b0, i_weight} + 9'd4;
        a5     = a5_sum[8:3];
        bgx    = gcpb_pkg::spread565(i_background[15:0]);
        diff   = i_cfg.fg_spread - bgx;
        n_p565 = diff * 32'(a5);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
            r_p565  <= n_p565;
            r_cov2  <= i_cov;
            r_bg2   <= i_background;
        end
    end

    // Stage three: finish the divisions and the RGB565 interpolation, then select.
    always_comb begin
        bgx3    = gcpb_pkg::spread565(r_bg2[15:0]);
        res565  = ((r_p565 >> 5) + bgx3) & gcpb_pkg::MASK565;
        fold565 = res565[31:16] | res565[15:0];
        mr      = gcpb_pkg::div255(r_sum_r);
        mg      = gcpb_pkg::div255(r_sum_g);
        mb      = gcpb_pkg::div255(r_sum_b);
        n_pixel = r_bg2;
        if (r_cov2) begin
            case (i_cfg.pixel_format)
                gcpb_pkg::FMT_RGB565:   n_pixel = {16'd0, fold565};
                gcpb_pkg::FMT_RGB888:   n_pixel = {8'd0, mr, mg, mb};
                gcpb_pkg::FMT_RGBA8888: n_pixel = {mr, mg, mb, 8'hFF};
                default:                n_pixel = r_bg2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r_pixel <= n_pixel;
            r_we    <= r_cov2;
        end
    end

    assign o_pixel_out    = r_pixel;
    assign o_write_enable = r_we;

endmodule

`default_nettype wire
